// ===== hw/rtl/sor_pkg.sv =====
// Shared types, codes and arithmetic helpers of the 1-D over-relaxation Poisson solver.
package sor_pkg;

  localparam int MaxPoints     = 64;
  localparam int AddrW         = $clog2(MaxPoints);
  localparam int CheckInterval = 25;
  localparam int ModW          = (CheckInterval > 1) ? $clog2(CheckInterval) : 1;
  localparam int SweepW        = 20;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 48;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GRID_POINTS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELAX_FACTOR   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESIDUAL_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SWEEPS     = 3'd4;

  // datapath steps
  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_LATCH    = 4'd1;
  localparam logic [3:0] DP_BND      = 4'd2;
  localparam logic [3:0] DP_SWP_INIT = 4'd3;
  localparam logic [3:0] DP_RES_INIT = 4'd4;
  localparam logic [3:0] DP_BLOAD    = 4'd5;
  localparam logic [3:0] DP_MUL      = 4'd6;
  localparam logic [3:0] DP_SRC      = 4'd7;
  localparam logic [3:0] DP_G        = 4'd8;
  localparam logic [3:0] DP_D        = 4'd9;
  localparam logic [3:0] DP_Q        = 4'd10;
  localparam logic [3:0] DP_R1       = 4'd11;
  localparam logic [3:0] DP_R2       = 4'd12;
  localparam logic [3:0] DP_R3       = 4'd13;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         point_index;
    logic signed [31:0] charge_value;
    logic signed [31:0] left_potential;
    logic signed [31:0] right_potential;
  } sor_in_t;

  typedef struct packed {
    logic signed [31:0] potential_value;
    logic               converged;
    logic [SweepW-1:0]  sweeps_done;
  } sor_out_t;

  typedef struct packed {
    logic [6:0]        grid_points;
    logic [31:0]       source_gain;
    logic [14:0]       relax_factor;
    logic [47:0]       residual_limit;
    logic [SweepW-1:0] max_sweeps;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       step;
    logic             chg_we;
    logic             chg_re;
    logic [AddrW-1:0] chg_addr;
    logic             pot_we;
    logic [AddrW-1:0] pot_waddr;
    logic             pot_re;
    logic [AddrW-1:0] pot_raddr;
  } ctl_t;

  typedef struct packed {
    logic               changed;
    logic               below_limit;
    logic signed [31:0] rd_data;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    if (v[79:31] == {49{v[79]}}) r = v[31:0];
    else if (v[79]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sor_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sor_datapath.sv =====
// Datapath: charge and potential stores, point window and relaxation/residual arithmetic.
module sor_datapath import sor_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  ctl_t    ctl_i,
  input  sor_in_t in_i,
  output sts_t    sts_o
);

  logic [31:0] chg_rdata, pot_rdata, pot_wdata;
  logic signed [31:0] rd_val;
  logic [MaxPoints-1:0] vld_q;
  logic rd_vld_q, changed_q;
  logic [63:0] sum_q, sq_q, sq_mul;
  logic signed [31:0] left_q, right_q, a_q, b_q, c_q, s_q, g_q;
  logic signed [64:0] mprod_q;
  logic signed [48:0] rprod_q;
  logic [35:0] abs_q;
  logic signed [33:0] g_sum;
  logic signed [31:0] g_val, s_val, q_val;
  logic signed [32:0] d_val;
  logic signed [79:0] q_wide;
  logic signed [35:0] lap, r_val;
  logic [64:0] sum_add;

  sor_ram #(.Width(32), .Depth(MaxPoints)) u_chg_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.chg_we),
    .waddr_i (ctl_i.chg_addr),
    .wdata_i (in_i.charge_value),
    .re_i    (ctl_i.chg_re),
    .raddr_i (ctl_i.chg_addr),
    .rdata_o (chg_rdata)
  );

  sor_ram #(.Width(32), .Depth(MaxPoints)) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.pot_we),
    .waddr_i (ctl_i.pot_waddr),
    .wdata_i (pot_wdata),
    .re_i    (ctl_i.pot_re),
    .raddr_i (ctl_i.pot_raddr),
    .rdata_o (pot_rdata)
  );

  // unwritten potentials read as zero
  assign rd_val = rd_vld_q ? $signed(pot_rdata) : 32'sd0;

  assign s_val  = sat32($signed({{15{mprod_q[64]}}, mprod_q}) >>> 16);
  assign g_sum  = $signed({{2{a_q[31]}}, a_q}) + $signed({{2{c_q[31]}}, c_q})
                + $signed({{2{s_q[31]}}, s_q});
  assign g_val  = sat32($signed({{47{g_sum[33]}}, g_sum[33:1]}));
  assign d_val  = $signed({g_q[31], g_q}) - $signed({b_q[31], b_q});
  assign q_wide = $signed({{48{b_q[31]}}, b_q})
                + ($signed({{31{rprod_q[48]}}, rprod_q}) >>> 14);
  assign q_val  = sat32(q_wide);

  assign lap    = $signed({{4{a_q[31]}}, a_q}) - $signed({{3{b_q[31]}}, b_q, 1'b0})
                + $signed({{4{c_q[31]}}, c_q});
  assign r_val  = -$signed({{4{s_q[31]}}, s_q}) - lap;
  assign sq_mul = {32'd0, abs_q[31:0]} * {32'd0, abs_q[31:0]};
  assign sum_add = {1'b0, sum_q} + {1'b0, sq_q};

  always_comb begin
    case (ctl_i.step)
      DP_LATCH: pot_wdata = in_i.left_potential;
      DP_BND:   pot_wdata = right_q;
      default:  pot_wdata = q_val;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      changed_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      if (ctl_i.pot_we) vld_q[ctl_i.pot_waddr] <= 1'b1;
      if (ctl_i.pot_re) rd_vld_q <= vld_q[ctl_i.pot_raddr];
      case (ctl_i.step)
        DP_SWP_INIT: changed_q <= 1'b0;
        DP_RES_INIT: sum_q <= '0;
        DP_Q:        if (q_val != b_q) changed_q <= 1'b1;
        // saturate the running sum at all ones
        DP_R3:       sum_q <= sum_add[64] ? '1 : sum_add[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.step)
      DP_LATCH: begin
        left_q  <= in_i.left_potential;
        right_q <= in_i.right_potential;
      end
      DP_SWP_INIT, DP_RES_INIT: a_q <= left_q;
      DP_BLOAD: b_q <= rd_val;
      DP_MUL: begin
        c_q     <= rd_val;
        mprod_q <= $signed({1'b0, cfg_i.source_gain}) * $signed(chg_rdata);
      end
      DP_SRC: s_q <= s_val;
      DP_G:   g_q <= g_val;
      DP_D:   rprod_q <= $signed({1'b0, cfg_i.relax_factor}) * d_val;
      DP_Q: begin
        a_q <= q_val;
        b_q <= c_q;
      end
      DP_R1: abs_q <= r_val[35] ? 36'(-r_val) : 36'(r_val);
      DP_R2: sq_q <= (abs_q[35:32] != 4'd0) ? '1 : sq_mul;
      DP_R3: begin
        a_q <= b_q;
        b_q <= c_q;
      end
      default: ;
    endcase
  end

  assign sts_o.changed     = changed_q;
  assign sts_o.below_limit = sum_q < {16'd0, cfg_i.residual_limit};
  assign sts_o.rd_data     = rd_val;

endmodule

// ===== hw/rtl/sor_ctrl.sv =====
// Controller: command handshake, result register and the sweep/residual sequencer.
module sor_ctrl import sor_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  sor_in_t  in_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sor_out_t out_data_o,
  input  sts_t     sts_i,
  output ctl_t     ctl_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BND   = 4'd1;
  localparam logic [3:0] ST_WINIT = 4'd2;
  localparam logic [3:0] ST_BLOAD = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_SRC   = 4'd6;
  localparam logic [3:0] ST_G     = 4'd7;
  localparam logic [3:0] ST_D     = 4'd8;
  localparam logic [3:0] ST_Q     = 4'd9;
  localparam logic [3:0] ST_R1    = 4'd10;
  localparam logic [3:0] ST_R2    = 4'd11;
  localparam logic [3:0] ST_R3    = 4'd12;
  localparam logic [3:0] ST_SDEC  = 4'd13;
  localparam logic [3:0] ST_RDEC  = 4'd14;

  logic [3:0] state_q;
  logic [AddrW-1:0] i_q;
  logic [SweepW-1:0] it_q, cnt_q;
  logic [ModW-1:0] m_q, m_next;
  logic conv_q, res_q, pend_q, pend_rd_q, out_valid_q;
  sor_out_t out_q;

  logic [6:0] n_pts;
  logic [AddrW-1:0] last_i, right_addr;
  logic out_free, can_accept, acc, more, chk_ok;
  logic [SweepW:0] it_next, next_chk;

  always_comb begin
    if (cfg_i.grid_points < 7'd3) n_pts = 7'd3;
    else if (cfg_i.grid_points > 7'(MaxPoints)) n_pts = 7'(MaxPoints);
    else n_pts = cfg_i.grid_points;
  end
  assign last_i     = AddrW'(n_pts - 7'd2);
  assign right_addr = AddrW'(n_pts - 7'd1);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_accept = (state_q == ST_IDLE) && (!pend_q || out_free);
  assign in_stall_o = !can_accept;
  assign acc        = in_valid_i && can_accept;

  assign it_next  = {1'b0, it_q} + 1'b1;
  assign more     = it_next < {1'b0, cfg_i.max_sweeps};
  assign next_chk = {1'b0, it_q} + (SweepW+1)'(CheckInterval) - (SweepW+1)'(m_q);
  assign chk_ok   = next_chk < {1'b0, cfg_i.max_sweeps};
  assign m_next   = (m_q == ModW'(CheckInterval - 1)) ? '0 : m_q + 1'b1;

  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_i.cmd)
            CMD_LOAD: begin
              ctl_o.chg_we   = 1'b1;
              ctl_o.chg_addr = in_i.point_index;
            end
            CMD_SOLVE: begin
              ctl_o.step      = DP_LATCH;
              ctl_o.pot_we    = 1'b1;
              ctl_o.pot_waddr = '0;
            end
            CMD_READ: begin
              ctl_o.pot_re    = 1'b1;
              ctl_o.pot_raddr = in_i.point_index;
            end
            default: ;
          endcase
        end
      end
      ST_BND: begin
        ctl_o.step      = DP_BND;
        ctl_o.pot_we    = 1'b1;
        ctl_o.pot_waddr = right_addr;
      end
      ST_WINIT: begin
        ctl_o.step      = res_q ? DP_RES_INIT : DP_SWP_INIT;
        ctl_o.pot_re    = 1'b1;
        ctl_o.pot_raddr = AddrW'(1);
      end
      ST_BLOAD: ctl_o.step = DP_BLOAD;
      ST_RD: begin
        ctl_o.pot_re    = 1'b1;
        ctl_o.pot_raddr = i_q + 1'b1;
        ctl_o.chg_re    = 1'b1;
        ctl_o.chg_addr  = i_q;
      end
      ST_MUL: ctl_o.step = DP_MUL;
      ST_SRC: ctl_o.step = DP_SRC;
      ST_G:   ctl_o.step = DP_G;
      ST_D:   ctl_o.step = DP_D;
      ST_Q: begin
        ctl_o.step      = DP_Q;
        ctl_o.pot_we    = 1'b1;
        ctl_o.pot_waddr = i_q;
      end
      ST_R1: ctl_o.step = DP_R1;
      ST_R2: ctl_o.step = DP_R2;
      ST_R3: ctl_o.step = DP_R3;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      it_q        <= '0;
      m_q         <= '0;
      cnt_q       <= '0;
      conv_q      <= 1'b0;
      res_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_rd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // move a pending result into the output register
      if (pend_q && out_free) begin
        // a new load, read or no-op transaction refills the slot below
        if (!(acc && in_i.cmd != CMD_SOLVE)) pend_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (in_i.cmd == CMD_SOLVE) begin
              state_q <= ST_BND;
            end else begin
              pend_q    <= 1'b1;
              pend_rd_q <= (in_i.cmd == CMD_READ);
            end
          end
        end
        ST_BND: begin
          conv_q <= 1'b0;
          cnt_q  <= cfg_i.max_sweeps;
          it_q   <= '0;
          m_q    <= '0;
          res_q  <= 1'b0;
          i_q    <= AddrW'(1);
          if (cfg_i.max_sweeps == '0) begin
            pend_q    <= 1'b1;
            pend_rd_q <= 1'b0;
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_WINIT;
          end
        end
        ST_WINIT: state_q <= ST_BLOAD;
        ST_BLOAD: state_q <= ST_RD;
        ST_RD:    state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_SRC;
        ST_SRC:   state_q <= res_q ? ST_R1 : ST_G;
        ST_G:     state_q <= ST_D;
        ST_D:     state_q <= ST_Q;
        ST_Q: begin
          if (i_q == last_i) state_q <= ST_SDEC;
          else begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_R1: state_q <= ST_R2;
        ST_R2: state_q <= ST_R3;
        ST_R3: begin
          if (i_q == last_i) state_q <= ST_RDEC;
          else begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_SDEC: begin
          i_q <= AddrW'(1);
          if (m_q == '0 || !sts_i.changed) begin
            res_q   <= 1'b1;
            state_q <= ST_WINIT;
          end else if (more) begin
            it_q    <= it_next[SweepW-1:0];
            m_q     <= m_next;
            state_q <= ST_WINIT;
          end else begin
            pend_q    <= 1'b1;
            pend_rd_q <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        ST_RDEC: begin
          i_q   <= AddrW'(1);
          res_q <= 1'b0;
          if (m_q == '0) begin
            if (sts_i.below_limit) begin
              conv_q    <= 1'b1;
              cnt_q     <= it_next[SweepW-1:0];
              pend_q    <= 1'b1;
              pend_rd_q <= 1'b0;
              state_q   <= ST_IDLE;
            end else if (sts_i.changed && more) begin
              it_q    <= it_next[SweepW-1:0];
              m_q     <= m_next;
              state_q <= ST_WINIT;
            end else begin
              pend_q    <= 1'b1;
              pend_rd_q <= 1'b0;
              state_q   <= ST_IDLE;
            end
          end else begin
            // no potential moved: the state is fixed, so jump to the next check
            if (chk_ok && sts_i.below_limit) begin
              conv_q <= 1'b1;
              cnt_q  <= SweepW'(next_chk + 1'b1);
            end
            pend_q    <= 1'b1;
            pend_rd_q <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_q.potential_value <= pend_rd_q ? sts_i.rd_data : 32'sd0;
      out_q.converged       <= conv_q;
      out_q.sweeps_done     <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("input taken while a solve is running");

  a_solve_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.cmd == CMD_SOLVE) |=> state_q == ST_BND)
    else $error("solve transaction did not start the sequencer");

  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(conv_q) |-> cnt_q != '0)
    else $error("convergence flagged with zero sweeps");

  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> ({1'b0, i_q} < n_pts - 7'd1))
    else $error("point index left the interior");

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_free) |=> pend_q)
    else $error("pending result dropped while output blocked");

endmodule

// ===== hw/rtl/sor_poisson_solver_1d.sv =====
// Top level of the 1-D over-relaxation Poisson solver: configuration registers and wiring.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  input    | in_valid_i/in_stall_o | in_data_i   (sor_in_t)
//  output   | out_valid_o/out_stall_i | out_data_o (sor_out_t)
//  config   | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Load and read transactions are taken one per cycle while no solve runs and the pending
// slot can drain; a read result passes through the pending slot into the output register.
// Solve length is set by the single potential read port and the six-step point sequencer.
// Reset sets the configuration to its defaults and marks every potential as zero at once.
// A stalled output holds one result while the next one waits in a pending slot.
module sor_poisson_solver_1d import sor_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sor_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sor_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  ctl_t ctl;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_points    <= 7'd64;
      cfg_q.source_gain    <= 32'd65536;
      cfg_q.relax_factor   <= 15'd22938;
      cfg_q.residual_limit <= 48'd1;
      cfg_q.max_sweeps     <= 20'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_POINTS:    cfg_q.grid_points    <= cfg_wdata_i[6:0];
        CFG_SOURCE_GAIN:    cfg_q.source_gain    <= cfg_wdata_i[31:0];
        CFG_RELAX_FACTOR:   cfg_q.relax_factor   <= cfg_wdata_i[14:0];
        CFG_RESIDUAL_LIMIT: cfg_q.residual_limit <= cfg_wdata_i[47:0];
        CFG_MAX_SWEEPS:     cfg_q.max_sweeps     <= cfg_wdata_i[SweepW-1:0];
        default: ;
      endcase
    end
  end

  sor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_i        (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  sor_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ctl_i  (ctl),
    .in_i   (in_data_i),
    .sts_o  (sts)
  );

endmodule

// ===== verif/sor_poisson_solver_1d_tb.sv =====
// Self-checking testbench for the 1-D over-relaxation Poisson solver.
`timescale 1ns / 1ps

module sor_poisson_solver_1d_tb;
  import sor_pkg::*;

  localparam int unsigned IdleLimit = 2000000;
  localparam logic [1:0]  CmdNop    = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sor_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sor_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  sor_poisson_solver_1d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // solver state as the block should hold it
  int                 charge_q[MaxPoints];
  int                 phi_q[MaxPoints];
  longint unsigned    res_sum_q;
  int unsigned        sweep_cnt_q;
  bit                 conv_q;
  int unsigned        grid_q, gain_q, relax_q, sweep_lim_q;
  longint unsigned    res_lim_q;

  sor_out_t           pending_results[$];
  int unsigned        errors, n_items, n_results, n_solves, n_conv, idle_cycles;
  int unsigned        out_hold;
  bit                 no_gaps;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint unsigned residual_energy(const ref int src[MaxPoints],
                                                     input int unsigned n);
    longint unsigned sum, sq, mag;
    longint          lap, r;
    sum = 0;
    for (int unsigned i = 1; i + 1 < n; i++) begin
      lap = longint'(phi_q[i-1]) - 2 * longint'(phi_q[i]) + longint'(phi_q[i+1]);
      r   = -longint'(src[i]) - lap;
      mag = (r < 0) ? longint'(-r) : r;
      sq  = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
      sum = (sum > ~sq) ? '1 : sum + sq;
    end
    return sum;
  endfunction

  function automatic void relax_grid(int left, int right);
    int              src[MaxPoints];
    int unsigned     n, nxt;
    int              p, g, q;
    longint          d;
    longint unsigned s;
    bit              changed;
    n = grid_q;
    if (n < 3) n = 3;
    if (n > MaxPoints) n = MaxPoints;
    for (int unsigned i = 0; i < n; i++)
      src[i] = clip32((longint'(gain_q) * longint'(charge_q[i])) >>> 16);
    phi_q[0]     = left;
    phi_q[n-1]   = right;
    conv_q       = 1'b0;
    sweep_cnt_q  = sweep_lim_q;
    for (int unsigned it = 0; it < sweep_lim_q; it++) begin
      changed = 1'b0;
      for (int unsigned i = 1; i + 1 < n; i++) begin
        p = phi_q[i];
        g = clip32((longint'(phi_q[i-1]) + longint'(phi_q[i+1]) + longint'(src[i])) >>> 1);
        d = longint'(g) - longint'(p);
        q = clip32(longint'(p) + ((longint'(relax_q) * d) >>> 14));
        if (q != p) changed = 1'b1;
        phi_q[i] = q;
      end
      if (it % CheckInterval == 0) begin
        res_sum_q = residual_energy(src, n);
        if (res_sum_q < res_lim_q) begin
          conv_q = 1'b1;
          sweep_cnt_q = it + 1;
          return;
        end
        if (!changed) return;
      end else if (!changed) begin
        // fixed point reached: jump to the next check
        nxt = it + (CheckInterval - it % CheckInterval);
        s = residual_energy(src, n);
        if (nxt < sweep_lim_q) begin
          res_sum_q = s;
          if (s < res_lim_q) begin
            conv_q = 1'b1;
            sweep_cnt_q = nxt + 1;
          end
        end
        return;
      end
    end
  endfunction

  function automatic sor_out_t predict_result(sor_in_t it);
    sor_out_t r;
    r.potential_value = '0;
    case (it.cmd)
      CMD_LOAD:  charge_q[it.point_index] = it.charge_value;
      CMD_SOLVE: begin
        relax_grid(it.left_potential, it.right_potential);
        n_solves++;
        if (conv_q) n_conv++;
      end
      CMD_READ:  r.potential_value = phi_q[it.point_index];
      default: ;
    endcase
    r.converged   = conv_q;
    r.sweeps_done = sweep_cnt_q[SweepW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // drive one transaction and wait until it is taken
  task automatic send_item(sor_in_t it, bit has_fixed, sor_out_t fixed);
    int unsigned gap;
    sor_out_t    r;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    r = predict_result(it);
    if (has_fixed && r != fixed) begin
      errors++;
      $display("[%0t] predictor disagrees with fixed expectation", $realtime);
    end
    pending_results.push_back(has_fixed ? fixed : r);
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i) cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_POINTS:    grid_q      = 32'(val[6:0]);
      CFG_SOURCE_GAIN:    gain_q      = val[31:0];
      CFG_RELAX_FACTOR:   relax_q     = 32'(val[14:0]);
      CFG_RESIDUAL_LIMIT: res_lim_q   = 64'(val[47:0]);
      CFG_MAX_SWEEPS:     sweep_lim_q = 32'(val[SweepW-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned g, int unsigned gain, int unsigned rf,
                           longint unsigned lim, int unsigned sw);
    write_reg(CFG_GRID_POINTS, CfgDataW'(g));
    write_reg(CFG_SOURCE_GAIN, CfgDataW'(gain));
    write_reg(CFG_RELAX_FACTOR, CfgDataW'(rf));
    write_reg(CFG_RESIDUAL_LIMIT, CfgDataW'(lim));
    write_reg(CFG_MAX_SWEEPS, CfgDataW'(sw));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      n_results++;
      out_hold = no_gaps ? 0 : $urandom_range(0, 4);
      if (pending_results.size() == 0) begin
        errors++;
        $display("[%0t] result with nothing expected", $realtime);
      end else begin
        sor_out_t w;
        w = pending_results.pop_front();
        if (out_data.potential_value !== w.potential_value)
          report_mismatch("potential_value", out_data.potential_value, w.potential_value);
        if (out_data.converged !== w.converged)
          report_mismatch("converged", out_data.converged, w.converged);
        if (out_data.sweeps_done !== w.sweeps_done)
          report_mismatch("sweeps_done", out_data.sweeps_done, w.sweeps_done);
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    logic [1:0] cmd;
    logic [5:0] idx;
    int         chg;
    int         lft;
    int         rgt;
    bit         fixed;
    int         pot;
  } vec_t;

  vec_t directed[] = '{
    '{CMD_READ,  6'd0,  0, 0, 0, 1, 0},
    '{CMD_READ,  6'd63, 0, 0, 0, 1, 0},
    '{CmdNop,    6'd5,  -1, -1, -1, 1, 0},
    '{CMD_LOAD,  6'd0,  32'sh7fff_ffff, 0, 0, 1, 0},
    '{CMD_LOAD,  6'd1,  32'sh8000_0000, 0, 0, 1, 0},
    '{CMD_LOAD,  6'd2,  0, 0, 0, 1, 0},
    '{CMD_LOAD,  6'd63, -1, 0, 0, 1, 0},
    '{CMD_SOLVE, 6'd0,  0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0},
    '{CMD_READ,  6'd0,  0, 0, 0, 0, 0},
    '{CMD_READ,  6'd1,  0, 0, 0, 0, 0},
    '{CMD_READ,  6'd2,  0, 0, 0, 0, 0},
    '{CMD_SOLVE, 6'd63, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0},
    '{CMD_READ,  6'd1,  0, 0, 0, 0, 0},
    '{CMD_LOAD,  6'd1,  32'sh0001_0000, 0, 0, 0, 0},
    '{CMD_SOLVE, 6'd0,  0, 0, 0, 0, 0},
    '{CMD_READ,  6'd1,  0, 0, 0, 0, 0},
    '{CmdNop,    6'd1,  0, 0, 0, 0, 0}
  };

  typedef struct {
    int unsigned     g, gain, rf, sw;
    longint unsigned lim;
    bit              quiet;
  } setting_t;

  setting_t settings[] = '{
    '{3,  65536,        22938, 40,       64'd1,            0},
    '{8,  0,            16384, 60,       64'd1 << 20,      0},
    '{16, 32'hffffffff, 32767, 30,       64'd0,            0},
    '{0,  100,          0,     0,        48'hffff_ffff_ffff, 0},
    '{127, 65536,       22938, 1000,     48'hffff_ffff_ffff, 1},
    '{64, 65536,        20000, 25,       64'd1 << 30,      0},
    '{5,  3000,         22938, 100,      64'd1 << 32,      0}
  };

  function automatic int draw_value(bit quiet, int unsigned span);
    if (quiet) return int'($urandom_range(0, 2 * span)) - int'(span);
    return int'($urandom());
  endfunction

  initial begin
    sor_in_t     it;
    sor_out_t    fx;
    int unsigned n, pick;

    grid_q = 64; gain_q = 65536; relax_q = 22938; res_lim_q = 1; sweep_lim_q = 1000000;
    foreach (charge_q[i]) charge_q[i] = 0;
    foreach (phi_q[i]) phi_q[i] = 0;
    res_sum_q = 0; sweep_cnt_q = 0; conv_q = 0;
    errors = 0; n_items = 0; n_results = 0; n_solves = 0; n_conv = 0;
    idle_cycles = 0; out_hold = 0; no_gaps = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // keep the directed solves short
    write_reg(CFG_GRID_POINTS, CfgDataW'(3));
    write_reg(CFG_MAX_SWEEPS, CfgDataW'(40));
    foreach (directed[k]) begin
      it = '{cmd: directed[k].cmd, point_index: directed[k].idx,
             charge_value: directed[k].chg, left_potential: directed[k].lft,
             right_potential: directed[k].rgt};
      fx = '{potential_value: directed[k].pot, converged: 1'b0, sweeps_done: '0};
      send_item(it, directed[k].fixed, fx);
    end
    wait_drained();

    foreach (settings[s]) begin
      write_all(settings[s].g, settings[s].gain, settings[s].rf, settings[s].lim,
                settings[s].sw);
      n = settings[s].g;
      if (n < 3) n = 3;
      if (n > MaxPoints) n = MaxPoints;
      // every charge in use must be written before a solve
      for (int unsigned i = 0; i < MaxPoints; i++) begin
        it = '0;
        it.cmd = CMD_LOAD;
        it.point_index = 6'(i);
        it.charge_value = draw_value(settings[s].quiet, 65536);
        send_item(it, 0, fx);
      end
      for (int unsigned k = 0; k < 65; k++) begin
        if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        it.point_index    = 6'($urandom());
        it.charge_value   = draw_value(settings[s].quiet, 65536);
        it.left_potential = draw_value(settings[s].quiet, 1 << 20);
        it.right_potential = draw_value(settings[s].quiet, 1 << 20);
        pick = $urandom_range(0, 99);
        if (pick < 45) it.cmd = CMD_LOAD;
        else if (pick < 80) it.cmd = CMD_READ;
        else if (pick < 92) it.cmd = CMD_SOLVE;
        else it.cmd = CmdNop;
        send_item(it, 0, fx);
      end
      no_gaps = 0;
      wait_drained();
    end

    $display("covered %0d transactions over %0d register settings: %0d solves, %0d converged",
             n_items, settings.size() + 1, n_solves, n_conv);
    $display("checked %0d results, %0d mismatches", n_results, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
